@@ design/csvfs_pkg.sv @@
// ---------------------------------------------------------------------------
// csvfs_pkg: shared types and constants for the CSV field splitter
// Result record layout, config register indexes and reset values.
// ---------------------------------------------------------------------------
package csvfs_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [IDX_W-1:0]  FIELD_MAX     = 10'd1023;
  localparam logic [CHAR_W-1:0] SEP_RESET     = 8'd44;   // ','
  localparam logic [CHAR_W-1:0] QUOTE_RESET   = 8'd34;   // '"'

  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTE     = 2'd1;

  localparam logic KIND_CONTENT   = 1'b0;
  localparam logic KIND_FIELD_END = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  fld_idx;
    logic              end_of_line;
    logic              last_of_run;
  } res_t;

endpackage

@@ design/csvfs_res_fifo.sv @@
// ---------------------------------------------------------------------------
// csvfs_res_fifo: result queue with up to two writes per cycle
// Small register queue; one or two results enter per cycle, one leaves.
// ---------------------------------------------------------------------------
module csvfs_res_fifo
  import csvfs_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push0_i,
  input  logic   push1_i,    // only with push0_i
  input  res_t   data0_i,
  input  res_t   data1_i,
  input  logic   pop_i,
  output logic   valid_o,
  output logic   almost_full_o,
  output res_t   data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_HIGH = CNT_W'(DEPTH - 2);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  res_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PTR_W-1:0] wr_ptr_nx;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign wr_ptr_nx = ptr_inc(wr_ptr_q);
  assign do_pop    = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push0_i && push1_i) begin
      wr_ptr_d = ptr_inc(wr_ptr_nx);
    end else if (push0_i) begin
      wr_ptr_d = wr_ptr_nx;
    end
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(push0_i) + CNT_W'(push0_i && push1_i) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push0_i && push1_i) begin
      mem_q[wr_ptr_nx] <= data1_i;
    end
  end

  assign valid_o       = (cnt_q != '0);
  assign almost_full_o = (cnt_q > CNT_HIGH);
  assign data_o        = mem_q[rd_ptr_q];

  // overflow would drop results
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push0_i |-> (cnt_q <= CNT_HIGH))
    else $error("result queue overflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("result count out of range");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1_i |-> push0_i)
    else $error("second write without first");

endmodule

@@ design/csv_field_splitter.sv @@
// ---------------------------------------------------------------------------
// csv_field_splitter: byte-serial CSV line splitter with RFC 4180 quoting
// Emits field content bytes and field-end markers through a result queue.
// ---------------------------------------------------------------------------
// Results are registered in the result queue before they reach the outputs.
// Throughput: one input byte per cycle while in_stall_o is low; an item that
//   yields two results (byte plus line end) sends them out one at a time,
//   limited by the single result port draining the result queue.
// Reset: quote flags and field counter clear, queue empties, separator
//   returns to ',' and quote to '"'. No clearing pass is needed.
// ---------------------------------------------------------------------------
module csv_field_splitter
  import csvfs_pkg::*;
#(
  parameter int unsigned RES_DEPTH = FIFO_DEPTH   // at least 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input bytes
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CHAR_W-1:0]    in_char_code_i,
  input  logic                 in_has_char_i,
  input  logic                 in_line_end_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 out_kind_o,
  output logic [CHAR_W-1:0]    out_char_o,
  output logic [IDX_W-1:0]     out_fld_idx_o,
  output logic                 out_end_of_line_o,
  output logic                 out_last_of_run_o,
  // config writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CHAR_W-1:0]    cfg_data_i
);

  // Config registers
  logic [CHAR_W-1:0] sep_q, quote_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= SEP_RESET;
      quote_q <= QUOTE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SEPARATOR: sep_q   <= cfg_data_i;
        REG_QUOTE:     quote_q <= cfg_data_i;
        default: ;     // unmapped index, write ignored
      endcase
    end
  end

  // Parser state
  logic             quoted_q, quoted_d;
  logic             pending_q, pending_d;
  logic [IDX_W-1:0] field_q, field_d;

  logic accept;
  logic is_quote, is_sep;
  logic byte_emit, byte_is_end, as_outside;
  logic push0, push1;
  res_t res0, res1, byte_res, eol_res;
  logic fifo_full;
  res_t head;

  assign accept   = in_valid_i && !in_stall_o;
  assign is_quote = (in_char_code_i == quote_q);
  assign is_sep   = (in_char_code_i == sep_q);

  // Byte rule, then line-end rule. The counter seen by the line-end marker
  // is the one after any separator in the same transaction.
  always_comb begin
    quoted_d    = quoted_q;
    pending_d   = pending_q;
    field_d     = field_q;
    byte_emit   = 1'b0;
    byte_is_end = 1'b0;
    as_outside  = 1'b0;

    if (in_has_char_i) begin
      if (quoted_q) begin
        if (pending_q) begin
          pending_d = 1'b0;
          if (is_quote) begin
            byte_emit = 1'b1;          // doubled quote -> literal quote
          end else begin
            quoted_d   = 1'b0;         // region closes, reprocess outside
            as_outside = 1'b1;
          end
        end else if (is_quote) begin
          pending_d = 1'b1;
        end else begin
          byte_emit = 1'b1;
        end
      end else begin
        as_outside = 1'b1;
      end

      if (as_outside) begin
        if (is_quote) begin
          quoted_d = 1'b1;             // quote wins over an equal separator
        end else if (is_sep) begin
          byte_emit   = 1'b1;
          byte_is_end = 1'b1;
          if (field_q != FIELD_MAX) begin
            field_d = field_q + IDX_W'(1);
          end
        end else begin
          byte_emit = 1'b1;
        end
      end
    end

    byte_res.kind        = byte_is_end ? KIND_FIELD_END : KIND_CONTENT;
    byte_res.char_code   = byte_is_end ? '0 : in_char_code_i;
    byte_res.fld_idx     = field_q;
    byte_res.end_of_line = 1'b0;
    byte_res.last_of_run = !in_line_end_i;

    eol_res.kind         = KIND_FIELD_END;
    eol_res.char_code    = '0;
    eol_res.fld_idx      = field_d;
    eol_res.end_of_line  = 1'b1;
    eol_res.last_of_run  = 1'b1;

    if (in_line_end_i) begin
      quoted_d  = 1'b0;
      pending_d = 1'b0;
      field_d   = '0;
    end

    res0  = byte_emit ? byte_res : eol_res;
    res1  = eol_res;
    push0 = accept && (byte_emit || in_line_end_i);
    push1 = accept && byte_emit && in_line_end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q  <= 1'b0;
      pending_q <= 1'b0;
      field_q   <= '0;
    end else if (accept) begin
      quoted_q  <= quoted_d;
      pending_q <= pending_d;
      field_q   <= field_d;
    end
  end

  // Result queue: stall input while fewer than two slots are free
  csvfs_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push0_i       (push0),
    .push1_i       (push1),
    .data0_i       (res0),
    .data1_i       (res1),
    .pop_i         (!out_stall_i),
    .valid_o       (out_valid_o),
    .almost_full_o (fifo_full),
    .data_o        (head)
  );

  assign in_stall_o        = fifo_full;
  assign out_kind_o        = head.kind;
  assign out_char_o        = head.char_code;
  assign out_fld_idx_o     = head.fld_idx;
  assign out_end_of_line_o = head.end_of_line;
  assign out_last_of_run_o = head.last_of_run;

  // line end leaves a clean state behind
  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_line_end_i) |=> (!quoted_q && !pending_q && field_q == '0))
    else $error("state not cleared at line end");

  // a pending quote only exists inside a quoted region
  a_pending_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> quoted_q)
    else $error("pending quote outside quotes");

  // a line end always produces a result
  a_eol_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_line_end_i) |-> push0)
    else $error("line end without result");

endmodule
